// File: design/cdt_pkg.sv
// cdt_pkg: shared constants, types and constant divide and multiply helpers for the
// countdown timer with meter. No dependencies.
`default_nettype none

package cdt_pkg;

    localparam int unsigned SecW   = 13;   // seconds count
    localparam int unsigned PreW   = 8;    // prescaler
    localparam int unsigned LockW  = 8;    // lockout counter
    localparam int unsigned MinW   = 8;    // whole minutes / meter units
    localparam int unsigned DutyW  = 10;   // meter duty and full scale
    localparam int unsigned ProdW  = DutyW + MinW;
    localparam int unsigned CfgW   = 10;   // widest register
    localparam int unsigned CfgAW  = 2;
    localparam int unsigned InW    = 8;    // input tdata, byte padded
    localparam int unsigned OutW   = DutyW + SecW + 1;

    // register indexes
    localparam logic [CfgAW-1:0] REG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CfgAW-1:0] REG_LOCKOUT_TICKS    = 2'd1;
    localparam logic [CfgAW-1:0] REG_METER_FULL_SCALE = 2'd2;

    // reset values
    localparam logic [PreW-1:0]  TPS_RESET    = 8'd64;
    localparam logic [LockW-1:0] LOCK_RESET   = 8'd20;
    localparam logic [DutyW-1:0] FS_RESET     = 10'd358;
    localparam logic [SecW-1:0]  SEC_RESET    = 13'd60;

    // timer constants
    localparam logic [SecW-1:0]  UP_LIMIT_S     = 13'd5400;
    localparam logic [SecW-1:0]  BIG_STEP_ABOVE = 13'd600;
    localparam logic [SecW-1:0]  FINE_BELOW     = 13'd570;
    localparam logic [SecW-1:0]  SECS_PER_MIN   = 13'd60;
    localparam logic [MinW-1:0]  STEP_SMALL     = 8'd1;
    localparam logic [MinW-1:0]  STEP_BIG       = 8'd5;
    localparam logic [SecW-1:0]  SECONDS_MAX    = 13'd8191;
    localparam logic [DutyW-1:0] DUTY_MAX       = 10'd1023;

    // stage loads for the meter pipeline
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_o;
    } pipe_ctl_t;

    // s / 60 for any 13-bit s: reciprocal 8739 / 2^19
    function automatic logic [MinW-1:0] div60(input logic [SecW-1:0] s);
        logic [26:0] p;
        p = 27'(s) * 27'd8739;
        return p[26:19];
    endfunction

    // s / 6 for any 10-bit s: reciprocal 683 / 2^12
    function automatic logic [MinW-1:0] div6(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * 20'd683;
        return p[19:12];
    endfunction

    // x / 100 for x below 199728 (full scale times at most 136 units):
    // reciprocal 167773 / 2^24
    function automatic logic [11:0] div100(input logic [ProdW-1:0] x);
        logic [35:0] p;
        p = 36'(x) * 36'd167773;
        return p[35:24];
    endfunction

    // minutes * 60 as shift and subtract
    function automatic logic [SecW:0] mul60(input logic [MinW-1:0] m);
        return ({6'd0, m} << 6) - ({6'd0, m} << 2);
    endfunction

endpackage

`default_nettype wire

// File: design/cdt_state.sv
// cdt_state: prescaler, seconds count and button lockout, updated once per
// accepted tick. Depends on cdt_pkg.
`default_nettype none

module cdt_state
    import cdt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              up_pressed,
    input  wire logic              down_pressed,
    input  wire logic [PreW-1:0]   ticks_per_second,
    input  wire logic [LockW-1:0]  lockout_ticks,
    output logic      [SecW-1:0]   sec_dec,      // seconds after the tick decrement
    output logic      [MinW-1:0]   min_dec,      // sec_dec / 60
    output logic      [SecW-1:0]   sec_next      // seconds after all updates
);

    logic [SecW-1:0]  sec_reg;
    logic [PreW-1:0]  pre_reg, pre_next, pre_inc;
    logic [LockW-1:0] lock_reg, lock_next;
    logic             take_sec;
    logic [MinW-1:0]  inc;
    logic [SecW:0]    up_val, dn_val;
    logic [SecW-1:0]  step_val;

    always_comb
    begin
        pre_inc  = pre_reg + PreW'(1);
        take_sec = (pre_inc >= ticks_per_second);
        sec_dec  = (take_sec && sec_reg != '0) ? sec_reg - SecW'(1) : sec_reg;
        min_dec  = div60(sec_dec);
        inc      = (sec_dec > BIG_STEP_ABOVE) ? STEP_BIG : STEP_SMALL;
        up_val   = mul60(min_dec + inc);
        dn_val   = mul60(min_dec - inc);

        if (up_pressed)
        begin
            if (sec_dec > UP_LIMIT_S)
                step_val = sec_dec;
            else if (up_val > {1'b0, SECONDS_MAX})
                step_val = SECONDS_MAX;
            else
                step_val = up_val[SecW-1:0];
        end
        else
        begin
            if (sec_dec < SECS_PER_MIN)
                step_val = '0;
            else
                step_val = dn_val[SecW-1:0];
        end

        sec_next  = sec_dec;
        pre_next  = take_sec ? '0 : pre_inc;
        lock_next = lock_reg;
        if (lock_reg != '0)
        begin
            lock_next = lock_reg - LockW'(1);
        end
        else if (up_pressed || down_pressed)
        begin
            sec_next  = step_val;
            pre_next  = '0;
            lock_next = lockout_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg  <= SEC_RESET;
            pre_reg  <= '0;
            lock_reg <= LOCK_RESET;
        end
        else if (accept)
        begin
            sec_reg  <= sec_next;
            pre_reg  <= pre_next;
            lock_reg <= lock_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cdt_meter.sv
// cdt_meter: three-register pipeline that turns seconds into the meter duty
// and carries the seconds and expired flag alongside. Depends on cdt_pkg.
`default_nettype none

module cdt_meter
    import cdt_pkg::*;
(
    input  wire logic              clk,
    input  wire pipe_ctl_t         ctl,
    input  wire logic [SecW-1:0]   sec_dec,
    input  wire logic [MinW-1:0]   min_dec,
    input  wire logic [SecW-1:0]   sec_next,
    input  wire logic [DutyW-1:0]  meter_full_scale,
    output logic      [DutyW-1:0]  meter_duty,
    output logic      [SecW-1:0]   seconds_left,
    output logic                   expired
);

    logic [MinW-1:0]  units_a_reg;
    logic [SecW-1:0]  sec_a_reg, sec_b_reg, sec_o_reg;
    logic [ProdW-1:0] prod_b_reg;
    logic [DutyW-1:0] duty_o_reg;
    logic [MinW-1:0]  units;
    logic [11:0]      quot;
    logic [DutyW-1:0] duty;

    always_comb
    begin
        units = (sec_dec < FINE_BELOW) ? div6(sec_dec[9:0]) : min_dec;
        quot  = div100(prod_b_reg);
        duty  = (quot > 12'(DUTY_MAX)) ? DUTY_MAX : quot[DutyW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            units_a_reg <= units;
            sec_a_reg   <= sec_next;
        end
        if (ctl.load_b)
        begin
            prod_b_reg <= ProdW'(meter_full_scale) * ProdW'(units_a_reg);
            sec_b_reg  <= sec_a_reg;
        end
        if (ctl.load_o)
        begin
            duty_o_reg <= duty;
            sec_o_reg  <= sec_b_reg;
        end
    end

    assign meter_duty   = duty_o_reg;
    assign seconds_left = sec_o_reg;
    assign expired      = (sec_o_reg == '0);

endmodule

`default_nettype wire

// File: design/countdown_timer_with_meter.sv
// countdown_timer_with_meter: top level with configuration registers, stream
// handshake and pipeline valids. Depends on cdt_pkg, cdt_state, cdt_meter.
//
//  channel   dir  payload (low bit first)
//  s_axis    in   tdata[7:0]: up_pressed, down_pressed, zero pad
//  m_axis    out  tdata[23:0]: meter_duty[9:0], seconds_left[12:0], expired
//  cfg       in   cfg_we, cfg_addr[1:0], cfg_wdata[9:0]
//
// One tick is accepted per clock unless a stalled output has backed up the
// pipeline; its result passes through the meter pipeline (units, full-scale multiply, divide by 100).
// Timer state updates in the cycle the tick transfer happens.
// rst_n clears the counters to their reset values and empties the pipeline.
// Each stage holds while the one after it is full and cannot pass its result on,
// so a stalled output backs up into s_axis_tready without losing any result.
`default_nettype none

module countdown_timer_with_meter
    import cdt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [InW-1:0]    s_axis_tdata,   // up_pressed, down_pressed
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [OutW-1:0]   m_axis_tdata,   // meter_duty, seconds_left, expired
    input  wire logic              cfg_we,
    input  wire logic [CfgAW-1:0]  cfg_addr,
    input  wire logic [CfgW-1:0]   cfg_wdata
);

    logic [PreW-1:0]  tps_reg;
    logic [LockW-1:0] lock_cfg_reg;
    logic [DutyW-1:0] fs_reg;
    logic             va_reg, vb_reg, vo_reg;
    logic             rdy_a, rdy_b, rdy_o, accept;
    pipe_ctl_t        ctl;
    logic [SecW-1:0]  sec_dec, sec_next, seconds_left;
    logic [MinW-1:0]  min_dec;
    logic [DutyW-1:0] meter_duty;
    logic             expired;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg      <= TPS_RESET;
            lock_cfg_reg <= LOCK_RESET;
            fs_reg       <= FS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TICKS_PER_SECOND: tps_reg      <= cfg_wdata[PreW-1:0];
                REG_LOCKOUT_TICKS:    lock_cfg_reg <= cfg_wdata[LockW-1:0];
                REG_METER_FULL_SCALE: fs_reg       <= cfg_wdata[DutyW-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        rdy_o      = !vo_reg || m_axis_tready;
        rdy_b      = !vb_reg || rdy_o;
        rdy_a      = !va_reg || rdy_b;
        accept     = s_axis_tvalid && rdy_a;
        ctl.load_a = accept;
        ctl.load_b = va_reg && rdy_b;
        ctl.load_o = vb_reg && rdy_o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load_a)
                va_reg <= 1'b1;
            else if (rdy_b)
                va_reg <= 1'b0;
            if (ctl.load_b)
                vb_reg <= 1'b1;
            else if (rdy_o)
                vb_reg <= 1'b0;
            if (ctl.load_o)
                vo_reg <= 1'b1;
            else if (m_axis_tready)
                vo_reg <= 1'b0;
        end
    end

    cdt_state u_state (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .up_pressed       (s_axis_tdata[0]),
        .down_pressed     (s_axis_tdata[1]),
        .ticks_per_second (tps_reg),
        .lockout_ticks    (lock_cfg_reg),
        .sec_dec          (sec_dec),
        .min_dec          (min_dec),
        .sec_next         (sec_next)
    );

    cdt_meter u_meter (
        .clk              (clk),
        .ctl              (ctl),
        .sec_dec          (sec_dec),
        .min_dec          (min_dec),
        .sec_next         (sec_next),
        .meter_full_scale (fs_reg),
        .meter_duty       (meter_duty),
        .seconds_left     (seconds_left),
        .expired          (expired)
    );

    assign s_axis_tready = rdy_a;
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {expired, seconds_left, meter_duty};

endmodule

`default_nettype wire

// File: bench/testbench.sv
// testbench: self-checking bench for countdown_timer_with_meter, button ticks
// in on s_axis, meter and seconds readings out on m_axis, predicted tick by tick.
// Depends on cdt_pkg and the design sources.
module testbench
    import cdt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;

    // button levels as carried in the low tdata bits: {down, up}
    localparam logic [1:0] PRESS_NONE = 2'b00;
    localparam logic [1:0] PRESS_UP   = 2'b01;
    localparam logic [1:0] PRESS_DOWN = 2'b10;
    localparam logic [1:0] PRESS_BOTH = 2'b11;

    typedef enum {MIX_RANDOM, MIX_CLIMB, MIX_DESCEND, MIX_QUIET} press_mix_t;

    // same layout as m_axis_tdata, low bit first: duty, seconds, expired
    typedef struct packed {
        logic             expired;
        logic [SecW-1:0]  secs;
        logic [DutyW-1:0] duty;
    } reading_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [InW-1:0]    s_axis_tdata = '0;   // up_pressed, down_pressed, zero pad
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OutW-1:0]   m_axis_tdata;        // meter_duty, seconds_left, expired
    logic              cfg_we = 1'b0;
    logic [CfgAW-1:0]  cfg_addr = '0;
    logic [CfgW-1:0]   cfg_wdata = '0;

    countdown_timer_with_meter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // predicted timer state and register copies
    logic [PreW-1:0]  tps_cfg = TPS_RESET;
    logic [LockW-1:0] lock_cfg = LOCK_RESET;
    logic [DutyW-1:0] scale_cfg = FS_RESET;
    logic [SecW-1:0]  secs_left = SEC_RESET;
    logic [PreW-1:0]  prescale = '0;
    logic [LockW-1:0] lockout = LOCK_RESET;

    logic [1:0] ticks_pending [$];
    reading_t   readings_due [$];

    int  send_idle_pct = 12;
    int  recv_idle_pct = 67;
    int  hold_left = 0;
    bit  in_xfer = 1'b0;
    int  quiet_cycles = 0;
    int  mismatches = 0;
    int  readings_seen = 0;

    function automatic int unsigned step_minutes(input int unsigned s, input bit up);
        int unsigned mins;
        int unsigned inc;
        int unsigned r;
        mins = s / SECS_PER_MIN;
        inc = (s > BIG_STEP_ABOVE) ? STEP_BIG : STEP_SMALL;
        if (up) begin
            if (s > UP_LIMIT_S)
                return s;
            r = (mins + inc) * SECS_PER_MIN;
        end
        else begin
            if (s < SECS_PER_MIN)
                return 0;
            r = (mins - inc) * SECS_PER_MIN;
        end
        return (r > SECONDS_MAX) ? SECONDS_MAX : r;
    endfunction

    // one tick: prescaler, second decrement, meter, then button step
    function automatic reading_t advance_timer(input logic up, input logic dn);
        reading_t    r;
        int unsigned units;
        int unsigned duty;
        prescale = prescale + 1'b1;
        if (prescale >= tps_cfg) begin
            prescale = '0;
            if (secs_left != 0)
                secs_left = secs_left - 1'b1;
        end
        units = (secs_left < FINE_BELOW) ? secs_left / 6 : secs_left / SECS_PER_MIN;
        duty = (scale_cfg * units) / 100;
        if (duty > DUTY_MAX)
            duty = DUTY_MAX;
        if (lockout != 0)
            lockout = lockout - 1'b1;
        else if (up || dn) begin
            secs_left = SecW'(step_minutes(secs_left, up));
            prescale = '0;
            lockout = lock_cfg;
        end
        r.duty = DutyW'(duty);
        r.secs = secs_left;
        r.expired = (secs_left == 0);
        return r;
    endfunction

    // sender: next tick offered after a transfer or an idle cycle
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_xfer)
        begin
            if (ticks_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{(InW-2){1'b0}}, ticks_pending.pop_front()};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, or a long hold-off while the sender keeps offering
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        reading_t want;
        reading_t got;
        bit       out_xfer;
        in_xfer = rst_n && s_axis_tvalid && s_axis_tready;
        out_xfer = rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_TICKS_PER_SECOND: tps_cfg = cfg_wdata[PreW-1:0];
                    REG_LOCKOUT_TICKS:    lock_cfg = cfg_wdata[LockW-1:0];
                    REG_METER_FULL_SCALE: scale_cfg = cfg_wdata[DutyW-1:0];
                    default: ;
                endcase
            end
            if (in_xfer)
                readings_due.push_back(advance_timer(s_axis_tdata[0], s_axis_tdata[1]));
            if (out_xfer)
            begin
                got = reading_t'(m_axis_tdata);
                if (readings_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reading %0d: unexpected transfer, data %h",
                                 readings_seen, m_axis_tdata);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got.duty !== want.duty || got.secs !== want.secs
                        || got.expired !== want.expired)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("reading %0d: duty %0d/%0d secs %0d/%0d expired %0d/%0d",
                                     readings_seen, want.duty, got.duty, want.secs,
                                     got.secs, want.expired, got.expired);
                    end
                end
                readings_seen++;
            end
            if (in_xfer || out_xfer || cfg_we)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (ticks_pending.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
            @(negedge clk);
    endtask

    // called at a falling edge with the block idle
    task automatic write_regs(input int tps, input int lock, input int scale);
        cfg_we <= 1'b1;
        cfg_addr <= REG_TICKS_PER_SECOND;
        cfg_wdata <= CfgW'(tps);
        @(negedge clk);
        cfg_addr <= REG_LOCKOUT_TICKS;
        cfg_wdata <= CfgW'(lock);
        @(negedge clk);
        cfg_addr <= REG_METER_FULL_SCALE;
        cfg_wdata <= CfgW'(scale);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic reconfigure(input int tps, input int lock, input int scale);
        wait_drained();
        write_regs(tps, lock, scale);
        @(posedge clk);
    endtask

    task automatic queue_presses(input press_mix_t mix, input int n);
        int  up_pct;
        int  dn_pct;
        bit  up;
        bit  dn;
        case (mix)
            MIX_CLIMB:   begin up_pct = 75; dn_pct = 15; end
            MIX_DESCEND: begin up_pct = 8;  dn_pct = 70; end
            MIX_QUIET:   begin up_pct = 3;  dn_pct = 3;  end
            default:     begin up_pct = 30; dn_pct = 30; end
        endcase
        for (int i = 0; i < n; i++)
        begin
            up = ($urandom_range(99) < up_pct);
            dn = ($urandom_range(99) < dn_pct);
            ticks_pending.push_back({dn, up});
        end
    endtask

    task automatic run_phase(input int tps, input int lock, input int scale,
                             input press_mix_t mix, input int n, input int hold);
        reconfigure(tps, lock, scale);
        hold_left = hold;
        queue_presses(mix, n);
    endtask

    // ticks right after reset fall inside the reset lockout
    logic [1:0] locked_ticks [4] = '{PRESS_UP, PRESS_DOWN, PRESS_BOTH, PRESS_NONE};
    // one-second ticks, still inside the reset lockout: the count runs below a minute, presses ignored
    logic [1:0] opening [12] = '{PRESS_DOWN, PRESS_NONE, PRESS_BOTH, PRESS_UP,
                                 PRESS_UP, PRESS_UP, PRESS_DOWN, PRESS_DOWN,
                                 PRESS_DOWN, PRESS_NONE, PRESS_UP, PRESS_BOTH};

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (locked_ticks[i])
            ticks_pending.push_back(locked_ticks[i]);
        reconfigure(1, 0, 1023);
        foreach (opening[i])
            ticks_pending.push_back(opening[i]);

        // sender mostly busy, receiver mostly stalled
        run_phase(1, 0, 1023, MIX_CLIMB, 120, HOLD_CYCLES);
        run_phase(0, 3, 500, MIX_DESCEND, 100, 0);

        wait_drained();
        @(posedge clk);
        send_idle_pct = 67;
        recv_idle_pct = 12;
        run_phase(255, 255, 0, MIX_RANDOM, 100, 0);
        // prescaler may sit well above the new setting
        run_phase(2, 1, 358, MIX_RANDOM, 150, 0);

        wait_drained();
        @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(4, 0, 1023, MIX_CLIMB, 120, 0);
        run_phase(1, 2, 800, MIX_DESCEND, 80, 0);
        run_phase(64, 20, 358, MIX_RANDOM, 100, 0);
        run_phase(1, 0, 1, MIX_QUIET, 110, 0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
design/cdt_pkg.sv
design/cdt_state.sv
design/cdt_meter.sv
design/countdown_timer_with_meter.sv
bench/testbench.sv
